>>> rtl/svlp_pkg.sv
// Shared constants, types and saturation helpers for the state-variable low-pass filter.
`default_nettype none

package svlp_pkg;

  // Default widths of the sample and coefficient formats.
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COEF_WIDTH_DEF   = 32;

  // Filter state and intermediates are signed Q17.23.
  localparam int STATE_W = 40;
  localparam int HALF_W  = STATE_W / 2;

  // Register port geometry.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register indexes (word address).
  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_KF   = 3'd1;
  localparam logic [2:0] REG_KQ   = 3'd2;
  localparam logic [2:0] REG_A1   = 3'd3;
  localparam logic [2:0] REG_A2   = 3'd4;
  localparam logic [2:0] REG_A3   = 3'd5;

  // Filter algorithm selected by the mode register.
  localparam logic MODE_CHAMBERLIN = 1'b0;
  localparam logic MODE_TRAPEZOID  = 1'b1;

  // Sequencer step counter and the last step of each algorithm.
  localparam int          STEP_W       = 4;
  localparam logic [3:0]  LAST_STEP_CH = 4'd11;
  localparam logic [3:0]  LAST_STEP_TR = 4'd8;

  // Datapath update operations.
  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_LOW_ADD  = 4'd1,
    OP_HIGH_X   = 4'd2,
    OP_HIGH_Q   = 4'd3,
    OP_BAND_ADD = 4'd4,
    OP_V3       = 4'd5,
    OP_V1_LD    = 4'd6,
    OP_V1_ADD   = 4'd7,
    OP_V2_LD    = 4'd8,
    OP_V2_ADD   = 4'd9,
    OP_INTEG    = 4'd10
  } alu_op_t;

  // Multiplier coefficient operand.
  typedef enum logic [2:0] {
    CS_KF = 3'd0,
    CS_KQ = 3'd1,
    CS_A1 = 3'd2,
    CS_A2 = 3'd3,
    CS_A3 = 3'd4
  } coef_sel_t;

  // Multiplier value operand.
  typedef enum logic [1:0] {
    VS_BAND = 2'd0,
    VS_TMP  = 2'd1,
    VS_INT1 = 2'd2
  } val_sel_t;

  // Command word from the controller to the datapath.
  typedef struct packed {
    alu_op_t   op;
    coef_sel_t csel;
    val_sel_t  vsel;
    logic      x_load;
    logic      out_load;
  } svlp_cmd_t;

  // Sign-extend a state value by two bits for overflow-safe arithmetic.
  function automatic logic [STATE_W+1:0] ext_st(input logic [STATE_W-1:0] a);
    ext_st = {{2{a[STATE_W-1]}}, a};
  endfunction

  // Saturate a 42-bit signed value to the signed 40-bit state range.
  function automatic logic [STATE_W-1:0] sat_st(input logic [STATE_W+1:0] v);
    logic [2:0] top;
    top = v[STATE_W+1:STATE_W-1];
    if ((top == 3'b000) || (top == 3'b111)) begin
      sat_st = v[STATE_W-1:0];
    end else if (v[STATE_W+1]) begin
      sat_st = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      sat_st = {1'b0, {(STATE_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/svlp_regs.sv
// Configuration register file with the bus write and read decode.
`default_nettype none

module svlp_regs #(
  parameter int COEF_WIDTH = svlp_pkg::COEF_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [svlp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [svlp_pkg::DATA_W-1:0] pwdata,
  output logic      [svlp_pkg::DATA_W-1:0] prdata,
  output logic                             mode,
  output logic      [COEF_WIDTH-2:0]       coef_kf,
  output logic      [COEF_WIDTH-2:0]       coef_kq,
  output logic      [COEF_WIDTH-2:0]       coef_a1,
  output logic      [COEF_WIDTH-2:0]       coef_a2,
  output logic      [COEF_WIDTH-2:0]       coef_a3
);
  import svlp_pkg::*;

  localparam int CW = COEF_WIDTH - 1;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  // Register writes; unused data bits are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_CHAMBERLIN;
      coef_kf <= '0;
      coef_kq <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
      coef_a3 <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MODE: mode    <= pwdata[0];
        REG_KF:   coef_kf <= pwdata[CW-1:0];
        REG_KQ:   coef_kq <= pwdata[CW-1:0];
        REG_A1:   coef_a1 <= pwdata[CW-1:0];
        REG_A2:   coef_a2 <= pwdata[CW-1:0];
        REG_A3:   coef_a3 <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // Read mux, zero-extended to the bus width.
  always_comb begin
    case (reg_idx)
      REG_MODE: prdata = {{(DATA_W-1){1'b0}}, mode};
      REG_KF:   prdata = {{(DATA_W-CW){1'b0}}, coef_kf};
      REG_KQ:   prdata = {{(DATA_W-CW){1'b0}}, coef_kq};
      REG_A1:   prdata = {{(DATA_W-CW){1'b0}}, coef_a1};
      REG_A2:   prdata = {{(DATA_W-CW){1'b0}}, coef_a2};
      REG_A3:   prdata = {{(DATA_W-CW){1'b0}}, coef_a3};
      default:  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/svlp_cmul.sv
// Four-stage pipelined coefficient multiplier with symmetric rounding and saturation.
`default_nettype none

module svlp_cmul #(
  parameter int COEF_WIDTH = svlp_pkg::COEF_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic [COEF_WIDTH-2:0]        coef,
  input  wire logic [svlp_pkg::STATE_W-1:0] val,
  output logic      [svlp_pkg::STATE_W-1:0] prod
);
  import svlp_pkg::*;

  localparam int CW   = COEF_WIDTH - 1;
  localparam int FRAC = COEF_WIDTH - 2;
  localparam int PPW  = CW + HALF_W;
  localparam int PW   = STATE_W + CW;

  logic [CW-1:0]      c_r;
  logic [STATE_W-1:0] m_r;
  logic               neg_r;
  logic [PPW-1:0]     pp_lo;
  logic [PPW-1:0]     pp_hi;
  logic               neg_p;
  logic [PW-1:0]      sum;
  logic [STATE_W-1:0] mag;
  logic               neg_m;

  // Half of one least significant bit of the result, for rounding.
  localparam logic [PW-1:0] RND = PW'(1) << (FRAC - 1);

  assign sum = {pp_hi, {HALF_W{1'b0}}} + PW'(pp_lo) + RND;

  always_ff @(posedge clk) begin
    // Stage 0: operands, value as sign and magnitude.
    c_r   <= coef;
    neg_r <= val[STATE_W-1];
    m_r   <= val[STATE_W-1] ? (~val + STATE_W'(1)) : val;
    // Stage 1: two partial products over the halves of the magnitude.
    pp_lo <= c_r * m_r[HALF_W-1:0];
    pp_hi <= c_r * m_r[STATE_W-1:HALF_W];
    neg_p <= neg_r;
    // Stage 2: combine, round half up on the magnitude, drop the fraction.
    mag   <= sum[FRAC +: STATE_W];
    neg_m <= neg_p;
    // Stage 3: restore the sign and saturate.
    if (neg_m) begin
      if (mag[STATE_W-1] && (|mag[STATE_W-2:0])) begin
        prod <= {1'b1, {(STATE_W-1){1'b0}}};
      end else begin
        prod <= ~mag + STATE_W'(1);
      end
    end else if (mag[STATE_W-1]) begin
      prod <= {1'b0, {(STATE_W-1){1'b1}}};
    end else begin
      prod <= mag;
    end
  end

endmodule

`default_nettype wire

>>> rtl/svlp_dp.sv
// Filter datapath: state registers, saturating adders and the shared multiplier.
`default_nettype none

module svlp_dp #(
  parameter int SAMPLE_WIDTH = svlp_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = svlp_pkg::COEF_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire svlp_pkg::svlp_cmd_t     cmd,
  input  wire logic                    mode,
  input  wire logic [COEF_WIDTH-2:0]   coef_kf,
  input  wire logic [COEF_WIDTH-2:0]   coef_kq,
  input  wire logic [COEF_WIDTH-2:0]   coef_a1,
  input  wire logic [COEF_WIDTH-2:0]   coef_a2,
  input  wire logic [COEF_WIDTH-2:0]   coef_a3,
  input  wire logic [SAMPLE_WIDTH-1:0] sample_in,
  output logic      [SAMPLE_WIDTH-1:0] lowpass_out
);
  import svlp_pkg::*;

  localparam int SW = SAMPLE_WIDTH;

  logic [STATE_W-1:0]    low_state;
  logic [STATE_W-1:0]    band_state;
  logic [STATE_W-1:0]    integ_one;
  logic [STATE_W-1:0]    integ_two;
  logic [STATE_W-1:0]    x;
  logic [STATE_W-1:0]    tmp;
  logic [STATE_W-1:0]    acc1;
  logic [STATE_W-1:0]    acc2;
  logic [STATE_W-1:0]    prod;
  logic [COEF_WIDTH-2:0] mul_coef;
  logic [STATE_W-1:0]    mul_val;
  logic [STATE_W-1:0]    y;
  logic [STATE_W-SW:0]   y_top;
  logic [SW-1:0]         y_sat;

  // Multiplier operand selection.
  always_comb begin
    case (cmd.csel)
      CS_KF:   mul_coef = coef_kf;
      CS_KQ:   mul_coef = coef_kq;
      CS_A1:   mul_coef = coef_a1;
      CS_A2:   mul_coef = coef_a2;
      CS_A3:   mul_coef = coef_a3;
      default: mul_coef = coef_kf;
    endcase
    case (cmd.vsel)
      VS_BAND: mul_val = band_state;
      VS_TMP:  mul_val = tmp;
      VS_INT1: mul_val = integ_one;
      default: mul_val = band_state;
    endcase
  end

  svlp_cmul #(
    .COEF_WIDTH(COEF_WIDTH)
  ) u_cmul (
    .clk (clk),
    .coef(mul_coef),
    .val (mul_val),
    .prod(prod)
  );

  // Filter state, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_state  <= '0;
      band_state <= '0;
      integ_one  <= '0;
      integ_two  <= '0;
    end else begin
      case (cmd.op)
        OP_LOW_ADD:  low_state  <= sat_st(ext_st(low_state) + ext_st(prod));
        OP_BAND_ADD: band_state <= sat_st(ext_st(band_state) + ext_st(prod));
        OP_INTEG: begin
          integ_one <= sat_st({acc1[STATE_W-1], acc1, 1'b0} - ext_st(integ_one));
          integ_two <= sat_st({acc2[STATE_W-1], acc2, 1'b0} - ext_st(integ_two));
        end
        default: ;
      endcase
    end
  end

  // Working registers for the sample and the intermediates of one transaction.
  always_ff @(posedge clk) begin
    if (cmd.x_load) begin
      x <= {{(STATE_W-SW){sample_in[SW-1]}}, sample_in};
    end
    case (cmd.op)
      OP_HIGH_X: tmp  <= sat_st(ext_st(x) - ext_st(low_state));
      OP_HIGH_Q: tmp  <= sat_st(ext_st(tmp) - ext_st(prod));
      OP_V3:     tmp  <= sat_st(ext_st(x) - ext_st(integ_two));
      OP_V1_LD:  acc1 <= prod;
      OP_V1_ADD: acc1 <= sat_st(ext_st(acc1) + ext_st(prod));
      OP_V2_LD:  acc2 <= sat_st(ext_st(integ_two) + ext_st(prod));
      OP_V2_ADD: acc2 <= sat_st(ext_st(acc2) + ext_st(prod));
      default: ;
    endcase
  end

  // Output: the selected low-pass value saturated to the sample range.
  assign y     = (mode == MODE_TRAPEZOID) ? acc2 : low_state;
  assign y_top = y[STATE_W-1:SW-1];

  always_comb begin
    if ((&y_top) || (~|y_top)) begin
      y_sat = y[SW-1:0];
    end else if (y[STATE_W-1]) begin
      y_sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      lowpass_out <= y_sat;
    end
  end

endmodule

`default_nettype wire

>>> rtl/svlp_ctrl.sv
// Sequencer that steps the datapath through one filter update per transaction.
`default_nettype none

module svlp_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire logic            mode,
  output svlp_pkg::svlp_cmd_t  cmd
);
  import svlp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] last_step;
  logic              out_free;

  assign in_stall  = (state != S_IDLE);
  assign last_step = (mode == MODE_TRAPEZOID) ? LAST_STEP_TR : LAST_STEP_CH;
  assign out_free  = !out_valid || !out_stall;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid)            state_next = S_RUN;
      S_RUN:  if (step == last_step)   state_next = S_HOLD;
      S_HOLD: if (out_free)            state_next = S_IDLE;
      default:                         state_next = S_IDLE;
    endcase
  end

  // Command decode: multiplier issue and update schedule per step.
  always_comb begin
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.csel     = CS_KF;
    cmd.vsel     = VS_BAND;
    cmd.x_load   = (state == S_IDLE) && in_valid;
    cmd.out_load = (state == S_HOLD) && out_free;
    if (state == S_RUN) begin
      if (mode == MODE_CHAMBERLIN) begin
        case (step)
          4'd0: begin cmd.csel = CS_KF; cmd.vsel = VS_BAND; end
          4'd2: begin cmd.csel = CS_KQ; cmd.vsel = VS_BAND; end
          4'd4: cmd.op = OP_LOW_ADD;
          4'd5: cmd.op = OP_HIGH_X;
          4'd6: cmd.op = OP_HIGH_Q;
          4'd7: begin cmd.csel = CS_KF; cmd.vsel = VS_TMP; end
          4'd11: cmd.op = OP_BAND_ADD;
          default: ;
        endcase
      end else begin
        case (step)
          4'd0: begin cmd.op = OP_V3; cmd.csel = CS_A1; cmd.vsel = VS_INT1; end
          4'd1: begin cmd.csel = CS_A2; cmd.vsel = VS_TMP; end
          4'd2: begin cmd.csel = CS_A2; cmd.vsel = VS_INT1; end
          4'd3: begin cmd.csel = CS_A3; cmd.vsel = VS_TMP; end
          4'd4: cmd.op = OP_V1_LD;
          4'd5: cmd.op = OP_V1_ADD;
          4'd6: cmd.op = OP_V2_LD;
          4'd7: cmd.op = OP_V2_ADD;
          4'd8: cmd.op = OP_INTEG;
          default: ;
        endcase
      end
    end
  end

  // State, step counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_RUN) begin
        step <= step + STEP_W'(1);
      end else begin
        step <= '0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/state_variable_lowpass_filter.sv
// Top level of the state-variable low-pass filter.
// Each input transaction starts one filter update; the input stays stalled until
// the result is loaded into the output register, which waits while a pending
// result is stalled. Mode 0 updates take longer than mode 1 updates, set by the
// four-stage latency of the shared multiplier on each algorithm's dependent chain.
// Synchronous reset clears the registers, the filter state and the output valid.
`default_nettype none

module state_variable_lowpass_filter #(
  parameter int SAMPLE_WIDTH = svlp_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = svlp_pkg::COEF_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [SAMPLE_WIDTH-1:0]     sample_in,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [SAMPLE_WIDTH-1:0]     lowpass_out,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [svlp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [svlp_pkg::DATA_W-1:0] pwdata,
  output logic      [svlp_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);
  import svlp_pkg::*;

  logic                  mode;
  logic [COEF_WIDTH-2:0] coef_kf;
  logic [COEF_WIDTH-2:0] coef_kq;
  logic [COEF_WIDTH-2:0] coef_a1;
  logic [COEF_WIDTH-2:0] coef_a2;
  logic [COEF_WIDTH-2:0] coef_a3;
  svlp_cmd_t             cmd;

  // The register port never inserts wait states.
  assign pready = 1'b1;

  svlp_regs #(
    .COEF_WIDTH(COEF_WIDTH)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .mode   (mode),
    .coef_kf(coef_kf),
    .coef_kq(coef_kq),
    .coef_a1(coef_a1),
    .coef_a2(coef_a2),
    .coef_a3(coef_a3)
  );

  svlp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .mode     (mode),
    .cmd      (cmd)
  );

  svlp_dp #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .mode       (mode),
    .coef_kf    (coef_kf),
    .coef_kq    (coef_kq),
    .coef_a1    (coef_a1),
    .coef_a2    (coef_a2),
    .coef_a3    (coef_a3),
    .sample_in  (sample_in),
    .lowpass_out(lowpass_out)
  );

endmodule

`default_nettype wire

>>> rtl/svlp_checker.sv
// Port-level checker for the state-variable low-pass filter and its bind.
`default_nettype none

module svlp_checker #(
  parameter int SAMPLE_WIDTH = svlp_pkg::SAMPLE_WIDTH_DEF
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic [SAMPLE_WIDTH-1:0] lowpass_out
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(lowpass_out))
    else $error("stalled result changed");

  // One transaction at a time: the input closes right after a sample is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a transaction");

  // A new result only appears at the end of a filter update.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind state_variable_lowpass_filter svlp_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_svlp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .lowpass_out(lowpass_out)
);

`default_nettype wire

>>> tb/state_variable_lowpass_filter_test.sv
// Self-checking testbench for the state-variable low-pass filter in both filter modes.
`timescale 1ns / 1ps

module state_variable_lowpass_filter_test;
  import svlp_pkg::*;

  localparam int          SW         = 24;
  localparam logic [SW-1:0] SAMPLE_MAX = 24'h7F_FFFF;
  localparam logic [SW-1:0] SAMPLE_MIN = 24'h80_0000;
  localparam logic [31:0] COEF_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] COEF_ONE   = 32'h4000_0000;
  localparam longint      STATE_MAX  = 64'sh7F_FFFF_FFFF;
  localparam longint      STATE_MIN  = -STATE_MAX - 1;
  localparam longint      OUT_MAX    = 64'sh7F_FFFF;
  localparam longint      OUT_MIN    = -OUT_MAX - 1;
  // Word indexes past the last register; writes there must be ignored.
  localparam logic [2:0]  REG_SPARE_LO = 3'd6;
  localparam logic [2:0]  REG_SPARE_HI = 3'd7;
  localparam real         PI = 3.14159265358979;
  localparam int          DRAIN_LIMIT = 5000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic [SW-1:0]     sample_in = '0;
  logic              out_stall = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  wire               in_stall;
  wire               out_valid;
  wire  [SW-1:0]     lowpass_out;
  wire  [DATA_W-1:0] prdata;
  wire               pready;

  state_variable_lowpass_filter DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample_in(sample_in),
    .out_valid(out_valid), .out_stall(out_stall), .lowpass_out(lowpass_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Register shadow copy and filter state of the predictor.
  logic        mode_sh = MODE_CHAMBERLIN;
  logic [30:0] kf_sh = '0, kq_sh = '0, a1_sh = '0, a2_sh = '0, a3_sh = '0;
  longint      low_acc = 0, band_acc = 0, integ1_acc = 0, integ2_acc = 0;

  logic [SW-1:0] lowpass_expected[$];
  int mismatch_count = 0;
  int samples_sent = 0;
  int outputs_checked = 0;
  int trapezoid_samples = 0;
  int stall_pct = 0;
  int stall_run = 0;
  int audio_level = 0;

  // Saturate to the signed 40-bit state range.
  function automatic longint clamp_state(longint v);
    if (v > STATE_MAX) return STATE_MAX;
    if (v < STATE_MIN) return STATE_MIN;
    return v;
  endfunction

  // Q1.30 coefficient times state value, rounded half away from zero.
  function automatic longint coef_scale(logic [30:0] c, longint v);
    logic [71:0] prod;
    longint mag;
    longint r;
    mag  = (v < 0) ? -v : v;
    prod = 72'(mag) * 72'(c) + (72'd1 << 29);
    r    = longint'(prod[71:30]);
    return clamp_state((v < 0) ? -r : r);
  endfunction

  // Advance the filter by one sample and return the expected low-pass output.
  function automatic logic [SW-1:0] filter_predict(logic [SW-1:0] s);
    longint x, high, v1, v2, v3, y;
    x = longint'($signed(s));
    if (mode_sh == MODE_CHAMBERLIN) begin
      low_acc  = clamp_state(low_acc + coef_scale(kf_sh, band_acc));
      high     = clamp_state(x - low_acc);
      high     = clamp_state(high - coef_scale(kq_sh, band_acc));
      band_acc = clamp_state(band_acc + coef_scale(kf_sh, high));
      y = low_acc;
    end else begin
      v3 = clamp_state(x - integ2_acc);
      v1 = clamp_state(coef_scale(a1_sh, integ1_acc) + coef_scale(a2_sh, v3));
      v2 = clamp_state(integ2_acc + coef_scale(a2_sh, integ1_acc));
      v2 = clamp_state(v2 + coef_scale(a3_sh, v3));
      integ1_acc = clamp_state(2 * v1 - integ1_acc);
      integ2_acc = clamp_state(2 * v2 - integ2_acc);
      y = v2;
    end
    if (y > OUT_MAX) y = OUT_MAX;
    if (y < OUT_MIN) y = OUT_MIN;
    return y[SW-1:0];
  endfunction

  function automatic logic [31:0] reg_shadow(logic [2:0] idx);
    case (idx)
      REG_MODE: return {31'b0, mode_sh};
      REG_KF:   return {1'b0, kf_sh};
      REG_KQ:   return {1'b0, kq_sh};
      REG_A1:   return {1'b0, a1_sh};
      REG_A2:   return {1'b0, a2_sh};
      REG_A3:   return {1'b0, a3_sh};
      default:  return 32'b0;
    endcase
  endfunction

  // Real coefficient to unsigned Q1.30, clipped to the register range.
  function automatic logic [31:0] to_q130(real r);
    real s;
    s = r * 1073741824.0;
    if (s >= 2147483647.0) return COEF_MAX;
    if (s <= 0.0) return 32'b0;
    return $rtoi(s);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // Output side: check each result transaction, then drive the stall pattern.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (lowpass_expected.size() == 0) begin
        report_mismatch("output with no sample pending", 32'(lowpass_out), 32'b0);
      end else begin
        if (lowpass_out !== lowpass_expected[0]) begin
          report_mismatch("lowpass_out", 32'(lowpass_out), 32'(lowpass_expected[0]));
        end
        void'(lowpass_expected.pop_front());
        outputs_checked++;
      end
    end
    if (stall_run == 0) begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      stall_run <= $urandom_range(1, 20);
    end else begin
      stall_run <= stall_run - 1;
    end
  end

  // Offer one sample and hold it until the input transaction completes.
  task automatic send_sample(logic [SW-1:0] s);
    in_valid  <= 1'b1;
    sample_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lowpass_expected.push_back(filter_predict(s));
    samples_sent++;
    if (mode_sh == MODE_TRAPEZOID) trapezoid_samples++;
  endtask

  task automatic hold_off(int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every pending output has been checked.
  task automatic drain_outputs();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (lowpass_expected.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (lowpass_expected.size() != 0) begin
      report_mismatch("outputs never arrived", lowpass_expected.size(), 32'b0);
      lowpass_expected.delete();
    end
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_MODE: mode_sh = value[0];
      REG_KF:   kf_sh = value[30:0];
      REG_KQ:   kq_sh = value[30:0];
      REG_A1:   a1_sh = value[30:0];
      REG_A2:   a2_sh = value[30:0];
      REG_A3:   a3_sh = value[30:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic reg_read_check(logic [2:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== reg_shadow(idx)) report_mismatch("register read", prdata, reg_shadow(idx));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Load all six registers once the filter has gone idle.
  task automatic apply_config(logic m, logic [31:0] kf, logic [31:0] kq,
                              logic [31:0] a1, logic [31:0] a2, logic [31:0] a3);
    drain_outputs();
    reg_write(REG_MODE, {31'b0, m});
    reg_write(REG_KF, kf);
    reg_write(REG_KQ, kq);
    reg_write(REG_A1, a1);
    reg_write(REG_A2, a2);
    reg_write(REG_A3, a3);
  endtask

  // After reset all coefficients are zero, so the Chamberlin output stays at zero.
  task automatic test_reset_defaults();
    for (int i = 0; i <= 5; i++) reg_read_check(3'(i));
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    drain_outputs();
  endtask

  // Unused bits are dropped and writes past the last register change nothing.
  task automatic test_register_file();
    reg_write(REG_MODE, 32'hFFFF_FFFE);
    reg_write(REG_KF, 32'hFFFF_FFFF);
    reg_write(REG_KQ, 32'h8000_0001);
    reg_write(REG_A1, 32'h5555_5555);
    reg_write(REG_A2, 32'hAAAA_AAAA);
    reg_write(REG_A3, COEF_MAX);
    reg_write(REG_SPARE_LO, 32'hFFFF_FFFF);
    reg_write(REG_SPARE_HI, 32'h1234_5678);
    for (int i = 0; i <= 5; i++) reg_read_check(3'(i));
    reg_write(REG_MODE, 32'hFFFF_FFFF);
    reg_read_check(REG_MODE);
  endtask

  // Chamberlin mode with a moderate setting, then the largest cutoff to force saturation.
  task automatic test_chamberlin_directed();
    apply_config(MODE_CHAMBERLIN, 32'h1000_0000, COEF_ONE, 0, 0, 0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    hold_off(3);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    apply_config(MODE_CHAMBERLIN, COEF_MAX, 0, 0, 0, 0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(24'h00_0001);
    drain_outputs();
  endtask

  // Trapezoidal mode at full-scale coefficients, then at a typical tuning.
  task automatic test_trapezoid_directed();
    real g, k, a1;
    apply_config(MODE_TRAPEZOID, 0, 0, COEF_MAX, COEF_MAX, COEF_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    g  = 0.1;
    k  = 1.0;
    a1 = 1.0 / (1.0 + g * (g + k));
    apply_config(MODE_TRAPEZOID, 0, 0, to_q130(a1), to_q130(g * a1), to_q130(g * g * a1));
    send_sample(24'hFF_FFFF);
    send_sample('0);
    send_sample(SAMPLE_MIN);
    drain_outputs();
  endtask

  // Each algorithm keeps its own state across a switch to the other one.
  task automatic test_mode_switch();
    apply_config(MODE_CHAMBERLIN, 32'h0800_0000, COEF_ONE, 32'h3000_0000,
                 32'h0400_0000, 32'h0080_0000);
    send_sample(24'h40_0000);
    send_sample(24'h40_0000);
    drain_outputs();
    reg_write(REG_MODE, {31'b0, MODE_TRAPEZOID});
    send_sample(24'hC0_0000);
    drain_outputs();
    reg_write(REG_MODE, {31'b0, MODE_CHAMBERLIN});
    send_sample(24'h20_0000);
    drain_outputs();
  endtask

  // Random phases: a fresh register setting each, mostly smooth audio in random bursts.
  task automatic test_random_phases(int phases, int per_phase);
    real fc, res, g, k, kf_r, kq_r, a1_r, a2_r, a3_r;
    logic [31:0] words[6];
    logic [SW-1:0] s;
    int sent, burst, style, step, pick;
    bit paused;
    for (int p = 0; p < phases; p++) begin
      fc   = 0.001 + 0.2 * ($urandom_range(0, 1000) / 1000.0);
      res  = $urandom_range(0, 950) / 1000.0;
      g    = $tan(PI * fc);
      k    = 2.0 - 2.0 * res;
      kf_r = 2.0 * $sin(PI * fc);
      kq_r = k;
      a1_r = 1.0 / (1.0 + g * (g + k));
      a2_r = g * a1_r;
      a3_r = g * a2_r;
      words[1] = to_q130(kf_r);
      words[2] = to_q130(kq_r);
      words[3] = to_q130(a1_r);
      words[4] = to_q130(a2_r);
      words[5] = to_q130(a3_r);
      // Some coefficients are replaced by extremes or raw random words.
      for (int r = 1; r <= 5; r++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) words[r] = 32'b0;
        else if (pick == 1) words[r] = COEF_MAX;
        else if (pick == 2) words[r] = $urandom;
      end
      words[0] = {$urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'b0, 1'((p % 2) ^ (p / 4))};
      stall_pct = (p % 4 == 0) ? 0 : $urandom_range(10, 70);
      apply_config(words[0][0], words[1], words[2], words[3], words[4], words[5]);
      reg_write(REG_MODE, words[0]);
      sent   = 0;
      paused = 0;
      while (sent < per_phase) begin
        burst = $urandom_range(1, 10);
        style = $urandom_range(0, 9);
        step  = 1 << $urandom_range(4, 20);
        for (int b = 0; b < burst && sent < per_phase; b++) begin
          if (style <= 1) begin
            s = 24'($urandom);
          end else if (style == 2) begin
            case ($urandom_range(0, 4))
              0: s = SAMPLE_MAX;
              1: s = SAMPLE_MIN;
              2: s = '0;
              3: s = 24'h00_0001;
              default: s = 24'hFF_FFFF;
            endcase
          end else begin
            audio_level += int'($urandom_range(0, 2 * step)) - step;
            if (audio_level > int'(OUT_MAX)) audio_level = int'(OUT_MAX);
            if (audio_level < int'(OUT_MIN)) audio_level = int'(OUT_MIN);
            s = audio_level[SW-1:0];
          end
          send_sample(s);
          sent++;
        end
        // Once per phase the sender waits for the filter to empty completely.
        if (!paused && sent >= per_phase / 2) begin
          paused = 1;
          drain_outputs();
        end else if ($urandom_range(0, 3) != 0) begin
          hold_off($urandom_range(1, 30));
        end
      end
    end
    stall_pct = 0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_register_file();
    test_chamberlin_directed();
    test_trapezoid_directed();
    test_mode_switch();
    test_random_phases(8, 100);
    drain_outputs();
    repeat (20) @(posedge clk);
    $display("Sent %0d samples and checked %0d outputs; %0d of them in trapezoidal mode.",
             samples_sent, outputs_checked, trapezoid_samples);
    $display("Register readback, ignored spare addresses, saturation and mode switches covered.");
    if (mismatch_count == 0) begin
      $display("** state_variable_lowpass_filter: PASSED **");
    end else begin
      $display("** state_variable_lowpass_filter: FAILED **");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("** state_variable_lowpass_filter: FAILED **");
    $finish;
  end

endmodule
